FILE: hdl/bmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmsd_pkg
// Shared constants for the byte memory with sprite copy engine.
// ----------------------------------------------------------------------------
package bmsd_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned COPY_LENGTH = 160;

  localparam logic [ADDR_W-1:0] DIVIDER_ADDR      = 16'hFF04;
  localparam logic [ADDR_W-1:0] COPY_TRIGGER_ADDR = 16'hFF46;
  localparam logic [ADDR_W-1:0] COPY_DEST_BASE    = 16'hFE00;

  // Index of the last byte moved by one copy
  localparam logic [7:0] COPY_LAST = 8'(COPY_LENGTH - 1);

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

endpackage : bmsd_pkg
`default_nettype wire

FILE: hdl/bmsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmsd_if
// Request and response channels of the byte memory (valid/ready).
// ----------------------------------------------------------------------------
interface bmsd_req_if import bmsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic              from_program;

  modport source (output valid, action, address, write_data, from_program, input ready);
  modport sink   (input valid, action, address, write_data, from_program, output ready);
endinterface : bmsd_req_if

interface bmsd_rsp_if import bmsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface : bmsd_rsp_if
`default_nettype wire

FILE: hdl/byte_memory_with_sprite_dma.sv
`timescale 1ns / 1ps
`default_nettype none
// Responses: a write word is answered in the cycle after acceptance, a read after
// the S_READ state, a copy trigger after a read and a write state per byte moved.
// Throughput: one plain write per cycle while the response side keeps up;
// reads pass through S_READ for the registered memory read before the next request.
// Reset: a clearing pass writes zero to all 65536 bytes, one per cycle;
// no request is accepted until the pass has ended.
// ----------------------------------------------------------------------------
// byte_memory_with_sprite_dma
// 64 KiB byte store with divider-clear write and a sequenced page copy.
// ----------------------------------------------------------------------------
module byte_memory_with_sprite_dma
  import bmsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  bmsd_req_if.sink    req,
  bmsd_rsp_if.source  rsp
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COPY_RD,
    S_COPY_WR
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        page;
  logic [7:0]        n;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
  logic [DATA_W-1:0] mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic accept;
  logic is_trigger;
  logic rsp_load;

  assign req.ready     = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept        = req.valid && req.ready;
  assign is_trigger    = (req.address == COPY_TRIGGER_ADDR);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  // Load a response word: plain write, finished read, or last copy byte
  assign rsp_load = (accept && (req.action == ACT_WRITE) && !is_trigger) ||
                    (state == S_READ) ||
                    ((state == S_COPY_WR) && (n == COPY_LAST));

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req.address;
    mem_wdata = req.write_data;
    mem_raddr = req.address;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (accept && (req.action == ACT_WRITE) && !is_trigger) begin
          mem_we = 1'b1;
          if ((req.address == DIVIDER_ADDR) && req.from_program) begin
            mem_wdata = '0;
          end
        end
      end
      S_READ: begin
      end
      S_COPY_RD: begin
        mem_raddr = {page, n};
      end
      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = COPY_DEST_BASE + {8'h00, n};
        mem_wdata = mem_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.action == ACT_READ) begin
              state <= S_READ;
            end else if (is_trigger) begin
              page  <= req.write_data;
              n     <= '0;
              state <= S_COPY_RD;
            end else begin
              out_data  <= '0;
            end
          end
        end
        S_READ: begin
          out_data  <= mem_q;
          state     <= S_IDLE;
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (n == COPY_LAST) begin
            // last byte moved: answer the trigger word
            out_data  <= '0;
            state     <= S_IDLE;
          end else begin
            n     <= n + 1'b1;
            state <= S_COPY_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("request accepted while sequencer busy");

  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == ACT_WRITE) && !is_trigger) |=>
      (rsp.valid && (rsp.read_data == '0)))
    else $error("plain write not answered with zero next cycle");

  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == ACT_READ)) |=> ##1 rsp.valid)
    else $error("read not answered two cycles after acceptance");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COPY_RD) || (state == S_COPY_WR)) |-> (n <= COPY_LAST))
    else $error("copy index ran past copy length");

  a_copy_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY_RD) |-> !rsp.valid)
    else $error("response raised during copy");

endmodule : byte_memory_with_sprite_dma
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte memory with sprite copy. A shadow copy of
// the 64 KiB store predicts each read byte, including divider clears and
// page copies. The bench runs directed accesses, then random traffic under
// several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import bmsd_pkg::*;

  // Covers the clearing pass after reset plus a generous margin
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 312;

  // --------------------------------------------------------------------------
  // Shadow store and queue of expected read bytes
  // --------------------------------------------------------------------------
  class byte_store_model;
    bit   [DATA_W-1:0] store [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] expected_bytes [$];
    int unsigned       mismatches;
    int unsigned       words_checked;

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch at response word %0d: %s", $realtime, words_checked, msg);
    endtask

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void take_request(logic act, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] data, logic prog);
      logic [ADDR_W-1:0] src_base;
      logic [ADDR_W-1:0] offset;
      if (act == ACT_READ) begin
        expected_bytes.push_back(store[addr]);
        return;
      end
      src_base = {data, 8'h00};
      if (addr == DIVIDER_ADDR && prog) begin
        store[addr] = '0;
      end else if (addr == COPY_TRIGGER_ADDR) begin
        // ascending order, as the copy engine moves the bytes
        for (int n = 0; n < COPY_LENGTH && n < 256; n++) begin
          offset = ADDR_W'(n);
          store[COPY_DEST_BASE + offset] = store[src_base + offset];
        end
      end else begin
        store[addr] = data;
      end
      expected_bytes.push_back('0);
    endfunction

    task check_read_data(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("response word 0x%02h with no request pending", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report($sformatf("read_data 0x%02h, expected 0x%02h", got, want));
      end
      words_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  bmsd_req_if req_bus ();
  bmsd_rsp_if rsp_bus ();

  byte_memory_with_sprite_dma i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  byte_store_model store_model = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_word(input logic act, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, input logic prog);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.action       <= act;
    req_bus.address      <= addr;
    req_bus.write_data   <= data;
    req_bus.from_program <= prog;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    store_model.take_request(act, addr, data, prog);
  endtask

  // Hold the request side quiet until every expected word has come back
  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    while (store_model.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_page();
    case ($urandom_range(0, 5))
      0:       return 8'hC0;
      1:       return 8'hC1;
      2:       return 8'hFE;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_word();
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              prog;
    int unsigned       kind;
    kind = $urandom_range(0, 99);
    act  = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
    data = 8'($urandom_range(0, 255));
    prog = 1'($urandom_range(0, 1));
    if (kind < 8) begin
      act  = ACT_WRITE;
      addr = COPY_TRIGGER_ADDR;
      data = pick_page();
    end else if (kind < 14) begin
      addr = DIVIDER_ADDR;
    end else if (kind < 55) begin
      // keep traffic on a few pages so reads and copies see written bytes
      addr = {pick_page(), 8'($urandom_range(0, 255))};
    end else begin
      addr = 16'($urandom_range(0, 65535));
    end
    send_word(act, addr, data, prog);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (ITEMS_PER_PHASE) send_random_word();
    drain_responses();
  endtask

  // --------------------------------------------------------------------------
  // Response side: check, then choose ready for the next edge
  // --------------------------------------------------------------------------
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        store_model.check_read_data(rsp_bus.read_data);
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Count cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                  <= 1'b1;
    req_bus.valid        <= 1'b0;
    req_bus.action       <= ACT_READ;
    req_bus.address      <= '0;
    req_bus.write_data   <= '0;
    req_bus.from_program <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners, divider clear, copies including self copy
    send_word(ACT_READ,  16'h0000, 8'h00, 1'b0);
    send_word(ACT_READ,  16'hFFFF, 8'hFF, 1'b1);
    send_word(ACT_WRITE, 16'hFFFF, 8'hFF, 1'b1);
    send_word(ACT_READ,  16'hFFFF, 8'h00, 1'b0);
    send_word(ACT_WRITE, 16'h0000, 8'h00, 1'b0);
    send_word(ACT_WRITE, DIVIDER_ADDR, 8'hAB, 1'b1);
    send_word(ACT_READ,  DIVIDER_ADDR, 8'h00, 1'b0);
    send_word(ACT_WRITE, DIVIDER_ADDR, 8'h5A, 1'b0);
    send_word(ACT_READ,  DIVIDER_ADDR, 8'h00, 1'b1);
    send_word(ACT_WRITE, 16'hC000, 8'h11, 1'b1);
    send_word(ACT_WRITE, 16'hC09F, 8'h99, 1'b0);
    send_word(ACT_WRITE, 16'hC0A0, 8'h77, 1'b1);
    send_word(ACT_WRITE, COPY_TRIGGER_ADDR, 8'hC0, 1'b1);
    send_word(ACT_READ,  16'hFE00, 8'h00, 1'b0);
    send_word(ACT_READ,  16'hFE9F, 8'h00, 1'b0);
    send_word(ACT_READ,  16'hFEA0, 8'h00, 1'b0);
    send_word(ACT_READ,  COPY_TRIGGER_ADDR, 8'h00, 1'b0);
    send_word(ACT_WRITE, COPY_TRIGGER_ADDR, 8'hFE, 1'b0);
    send_word(ACT_READ,  16'hFE00, 8'h00, 1'b0);
    send_word(ACT_WRITE, COPY_TRIGGER_ADDR, 8'hFF, 1'b0);
    send_word(ACT_READ,  16'hFE04, 8'h00, 1'b0);
    send_word(ACT_READ,  16'hFE46, 8'h00, 1'b0);
    send_word(ACT_WRITE, COPY_TRIGGER_ADDR, 8'h00, 1'b1);
    send_word(ACT_READ,  16'hFE00, 8'h00, 1'b0);
    drain_responses();

    // Random traffic under each stall pattern
    run_phase(0, 0);
    run_phase(72, 0);
    run_phase(0, 72);
    run_phase(6, 6);

    repeat (8) @(posedge clk);
    if (store_model.mismatches == 0 && store_model.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_top
